@@ src/bpfa_pkg.sv @@
// shared types, constants and helpers of the bitmap page frame allocator
package bpfa_pkg;

  localparam int ROW_BYTES = 8;
  localparam int LANE_W    = 3;
  localparam int BIT_W     = 3;
  localparam int ADDR_W    = 32;
  localparam int CMP_W     = 32;
  localparam int CFG_W     = 13;
  localparam int OP_W      = 2;
  localparam int STS_W     = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;
  localparam logic [7:0]       FULL_BYTE = 8'hFF;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_RANGE = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_EVAL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic latch_in;
    logic decode;
    logic eval;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_eval;
    logic eval_done;
    logic out_free;
  } sts_t;

  function automatic logic [BIT_W-1:0] lowest_clear(input logic [7:0] v);
    logic [BIT_W-1:0] k;
    k = '0;
    for (int i = 7; i >= 0; i--) begin
      if (!v[i]) begin
        k = BIT_W'(i);
      end
    end
    return k;
  endfunction

endpackage

@@ src/bpfa_ram.sv @@
// generic single write port, single read port ram with registered read
module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/bpfa_ctrl.sv @@
// controller state machine of the bitmap page frame allocator
module bpfa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bpfa_pkg::sts_t sts,
  output bpfa_pkg::cmd_t cmd
);
  import bpfa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = sts.need_eval ? S_EVAL : S_FINISH;
      end
      S_EVAL: begin
        if (sts.eval_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      S_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
      end
      S_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_accept_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DECODE))
    else $error("accepted request did not move to decode");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && sts.out_free) |=> (state_r == S_IDLE))
    else $error("finished request did not return to idle");

  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && !sts.eval_done) |=> (state_r == S_EVAL))
    else $error("scan left before completion");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command active");

endmodule

@@ src/bpfa_dp.sv @@
// datapath of the bitmap page frame allocator: bitmap ram, scan, result registers
module bpfa_dp #(
  parameter int BITMAP_BYTES = 4096,
  parameter int PAGE_SHIFT   = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpfa_pkg::cmd_t                cmd,
  output bpfa_pkg::sts_t                sts,
  input  logic [bpfa_pkg::OP_W-1:0]     in_opcode,
  input  logic [bpfa_pkg::ADDR_W-1:0]   in_phys_address,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpfa_pkg::CFG_W-1:0]    cfg_bytes_in_use,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bpfa_pkg::ADDR_W-1:0]   out_page_address,
  output logic                          out_page_used,
  output logic [bpfa_pkg::STS_W-1:0]    out_status
);
  import bpfa_pkg::*;

  localparam int ROWS   = (BITMAP_BYTES + ROW_BYTES - 1) / ROW_BYTES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DATA_W = ROW_BYTES * 8;
  localparam logic [CMP_W-1:0] MAX_BYTES = CMP_W'(BITMAP_BYTES);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

  logic [CFG_W-1:0]  cfg_r;
  logic [CMP_W-1:0]  lim_r;
  logic [CMP_W-1:0]  lim_nxt;
  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  row_nxt;
  logic [LANE_W-1:0] lane_r;
  logic [BIT_W-1:0]  bit_r;
  logic [ROW_W-1:0]  hint_r;
  logic [ROW_W-1:0]  hint_nxt;
  logic [ROW_W-1:0]  clr_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic [ADDR_W-1:0] res_addr_nxt;
  logic              res_used_r;
  logic              res_used_nxt;
  logic [STS_W-1:0]  res_status_r;
  logic [STS_W-1:0]  res_status_nxt;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_used_r;
  logic [STS_W-1:0]  out_status_r;

  logic              ram_wr_en;
  logic [ROW_W-1:0]  ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [ROW_W-1:0]  ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;

  logic [CMP_W-1:0]     byte_idx;
  logic                 in_range;
  logic [ROW_W-1:0]     dec_row;
  logic [LANE_W-1:0]    dec_lane;
  logic [BIT_W-1:0]     dec_bit;
  logic [ROW_BYTES-1:0] cand;
  logic                 found;
  logic [LANE_W-1:0]    hit_lane;
  logic [7:0]           hit_byte;
  logic [BIT_W-1:0]     hit_bit;
  logic [DATA_W-1:0]    set_mask;
  logic [DATA_W-1:0]    clr_mask;
  logic [CMP_W-1:0]     next_start;
  logic                 scan_last;
  logic [CMP_W-1:0]     page_num;
  logic [ADDR_W-1:0]    alloc_addr;
  logic                 need_eval;
  logic                 eval_done;
  logic                 out_free;

  bpfa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign cfg_ready = 1'b1;
  assign lim_nxt   = (CMP_W'(cfg_r) < MAX_BYTES) ? CMP_W'(cfg_r) : MAX_BYTES;

  // free and query address decode
  assign byte_idx = (addr_r >> PAGE_SHIFT) >> BIT_W;
  assign in_range = byte_idx < lim_r;
  assign dec_row  = byte_idx[ROW_W+LANE_W-1:LANE_W];
  assign dec_lane = byte_idx[LANE_W-1:0];
  assign dec_bit  = addr_r[PAGE_SHIFT +: BIT_W];

  // first non-full byte of the row inside the limit
  always_comb begin
    for (int j = 0; j < ROW_BYTES; j++) begin
      cand[j] = (CMP_W'({row_r, LANE_W'(j)}) < lim_r) &&
                (ram_rd_data[j*8 +: 8] != FULL_BYTE);
    end
  end

  always_comb begin
    hit_lane = '0;
    for (int j = ROW_BYTES - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit_lane = LANE_W'(j);
      end
    end
  end

  assign found      = |cand;
  assign hit_byte   = ram_rd_data[{hit_lane, BIT_W'(0)} +: 8];
  assign hit_bit    = lowest_clear(hit_byte);
  assign set_mask   = DATA_W'(1) << {hit_lane, hit_bit};
  assign clr_mask   = DATA_W'(1) << {lane_r, bit_r};
  assign next_start = CMP_W'({row_r, LANE_W'(0)}) + CMP_W'(ROW_BYTES);
  assign scan_last  = (next_start >= lim_r) || (row_r == LAST_ROW);
  assign page_num   = CMP_W'({row_r, hit_lane, hit_bit});
  assign alloc_addr = page_num << PAGE_SHIFT;

  always_comb begin
    ram_wr_en      = 1'b0;
    ram_wr_addr    = clr_r;
    ram_wr_data    = '0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = hint_r;
    row_nxt        = row_r;
    hint_nxt       = hint_r;
    res_addr_nxt   = res_addr_r;
    res_used_nxt   = res_used_r;
    res_status_nxt = res_status_r;
    need_eval      = 1'b0;
    eval_done      = 1'b0;
    if (cmd.clr_wr) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_r;
      ram_wr_data = '0;
    end
    if (cmd.decode) begin
      res_addr_nxt   = '0;
      res_used_nxt   = 1'b0;
      res_status_nxt = STS_OK;
      unique case (op_r)
        OP_ALLOC: begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = hint_r;
          row_nxt     = hint_r;
          need_eval   = 1'b1;
        end
        OP_FREE, OP_QUERY: begin
          if (in_range) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = dec_row;
            row_nxt     = dec_row;
            need_eval   = 1'b1;
            if (op_r == OP_FREE && dec_row < hint_r) begin
              hint_nxt = dec_row;
            end
          end else begin
            res_status_nxt = STS_RANGE;
          end
        end
        default: begin
          need_eval = 1'b0;
        end
      endcase
    end
    if (cmd.eval) begin
      unique case (op_r)
        OP_ALLOC: begin
          if (found) begin
            ram_wr_en      = 1'b1;
            ram_wr_addr    = row_r;
            ram_wr_data    = ram_rd_data | set_mask;
            hint_nxt       = row_r;
            res_addr_nxt   = alloc_addr;
            res_status_nxt = STS_OK;
            eval_done      = 1'b1;
          end else if (scan_last) begin
            res_status_nxt = STS_EMPTY;
            eval_done      = 1'b1;
          end else begin
            row_nxt     = row_r + ROW_W'(1);
            ram_rd_en   = 1'b1;
            ram_rd_addr = row_r + ROW_W'(1);
          end
        end
        OP_FREE: begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = row_r;
          ram_wr_data = ram_rd_data & ~clr_mask;
          eval_done   = 1'b1;
        end
        OP_QUERY: begin
          res_used_nxt = ram_rd_data[{lane_r, bit_r}];
          eval_done    = 1'b1;
        end
        default: begin
          eval_done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      hint_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_bytes_in_use;
      end
      hint_r <= hint_nxt;
      if (cmd.clr_wr) begin
        clr_r <= clr_r + ROW_W'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lim_r        <= lim_nxt;
    row_r        <= row_nxt;
    res_addr_r   <= res_addr_nxt;
    res_used_r   <= res_used_nxt;
    res_status_r <= res_status_nxt;
    if (cmd.latch_in) begin
      op_r   <= in_opcode;
      addr_r <= in_phys_address;
    end
    if (cmd.decode) begin
      lane_r <= dec_lane;
      bit_r  <= dec_bit;
    end
    if (cmd.load_out) begin
      out_addr_r   <= res_addr_r;
      out_used_r   <= res_used_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_free         = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_page_address = out_addr_r;
  assign out_page_used    = out_used_r;
  assign out_status       = out_status_r;

  assign sts.clr_last  = (clr_r == LAST_ROW);
  assign sts.need_eval = need_eval;
  assign sts.eval_done = eval_done;
  assign sts.out_free  = out_free;

  a_hint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hint_r <= LAST_ROW)
    else $error("scan hint beyond last row");

  a_hint_follows_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && op_r == OP_ALLOC && found) |=> (hint_r == $past(row_r)))
    else $error("scan hint not moved to allocated row");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

@@ src/bitmap_page_frame_allocator_core.sv @@
// top level of the bitmap page frame allocator
// an in-range free or query passes decode, eval and finish; an out-of-range one or an unknown
// opcode skips eval; an allocate stays in eval while it scans bitmap rows of 8 bytes from the hint
// one request at a time: the next is taken only in idle, after the result is loaded
// reset is synchronous; afterwards a clearing pass zeroes every row of the bitmap,
// during which requests stall and configuration writes are still taken
module bitmap_page_frame_allocator_core #(
  parameter int BITMAP_BYTES = 4096,
  parameter int PAGE_SHIFT   = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bpfa_pkg::OP_W-1:0]     in_opcode,
  input  logic [bpfa_pkg::ADDR_W-1:0]   in_phys_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bpfa_pkg::ADDR_W-1:0]   out_page_address,
  output logic                          out_page_used,
  output logic [bpfa_pkg::STS_W-1:0]    out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpfa_pkg::CFG_W-1:0]    cfg_bytes_in_use
);
  import bpfa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpfa_dp #(
    .BITMAP_BYTES (BITMAP_BYTES),
    .PAGE_SHIFT   (PAGE_SHIFT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_phys_address  (in_phys_address),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_bytes_in_use (cfg_bytes_in_use),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_page_address (out_page_address),
    .out_page_used    (out_page_used),
    .out_status       (out_status)
  );

endmodule

@@ verif/testbench.sv @@
// testbench of the bitmap page frame allocator: directed and random requests checked by a page bitmap predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bpfa_pkg::*;

  localparam int BITMAP_BYTES = 4096;
  localparam int PAGE_SHIFT   = 12;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic              page_used;
    logic [STS_W-1:0]  status;
  } page_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_opcode = '0;
  logic [ADDR_W-1:0]   in_phys_address = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ADDR_W-1:0]   out_page_address;
  logic                out_page_used;
  logic [STS_W-1:0]    out_status;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_bytes_in_use = '0;

  logic [7:0]          page_map [BITMAP_BYTES];
  logic [CFG_W-1:0]    bytes_in_use_q;
  page_result_t        pending_results [$];
  page_result_t        oldest_result;
  int                  mismatch_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  hold_cycles = 0;
  int unsigned         cycle_count = 0;

  bitmap_page_frame_allocator_core #(
    .BITMAP_BYTES(BITMAP_BYTES),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_phys_address (in_phys_address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_page_address(out_page_address),
    .out_page_used   (out_page_used),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_bytes_in_use(cfg_bytes_in_use)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding", $realtime, cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side stall, with a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic int unsigned active_bytes();
    return (bytes_in_use_q > BITMAP_BYTES) ? BITMAP_BYTES : int'(bytes_in_use_q);
  endfunction

  function automatic page_result_t predict_request(input logic [OP_W-1:0] op,
                                                   input logic [ADDR_W-1:0] addr);
    page_result_t r;
    int unsigned  lim;
    int unsigned  page_idx;
    int unsigned  byte_idx;
    int unsigned  bit_idx;
    logic [63:0]  full_addr;
    r = '0;
    lim = active_bytes();
    page_idx = addr >> PAGE_SHIFT;
    byte_idx = page_idx >> 3;
    bit_idx = page_idx & 7;
    case (op)
      OP_ALLOC: begin
        r.status = STS_EMPTY;
        for (int i = 0; i < lim && r.status == STS_EMPTY; i++) begin
          if (page_map[i] != FULL_BYTE) begin
            bit_idx = 8;
            for (int k = 0; k < 8; k++) begin
              if (bit_idx == 8 && !page_map[i][k]) bit_idx = k;
            end
            page_map[i][bit_idx] = 1'b1;
            full_addr = (64'(i) * 8 + 64'(bit_idx)) << PAGE_SHIFT;
            r.page_address = full_addr[31:0];
            r.status = STS_OK;
          end
        end
      end
      OP_FREE, OP_QUERY: begin
        if (byte_idx >= lim) begin
          r.status = STS_RANGE;
        end else if (op == OP_FREE) begin
          page_map[byte_idx][bit_idx] = 1'b0;
        end else begin
          r.page_used = page_map[byte_idx][bit_idx];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (expected !== actual) begin
      mismatch_count++;
      $display("%0t %s mismatch: expected %h actual %h", $realtime, name, expected, actual);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result: expected none actual %h %b %h", $realtime,
                 out_page_address, out_page_used, out_status);
      end else begin
        oldest_result = pending_results.pop_front();
        check_field("page_address", oldest_result.page_address, out_page_address);
        check_field("page_used", 32'(oldest_result.page_used), 32'(out_page_used));
        check_field("status", 32'(oldest_result.status), 32'(out_status));
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_phys_address <= addr;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_request(op, addr));
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_bytes_in_use(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_bytes_in_use <= value;
    do @(posedge clk); while (!cfg_ready);
    bytes_in_use_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_bytes_in_use();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CFG_W'($urandom_range(1, 4));
    if (r < 65) return CFG_W'($urandom_range(5, 200));
    if (r < 80) return CFG_W'(BITMAP_BYTES);
    if (r < 90) return CFG_W'($urandom_range(BITMAP_BYTES + 1, 8191));
    if (r < 95) return '0;
    return CFG_W'($urandom_range(0, 8191));
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned pages;
    int unsigned near;
    int r;
    pages = active_bytes() * 8;
    near = (pages < 64) ? pages : 64;
    r = $urandom_range(99);
    if (r < 50) return ADDR_W'($urandom_range(0, near + 7)) << PAGE_SHIFT | $urandom_range(0, 4095);
    if (r < 75) return ADDR_W'($urandom_range(0, pages + 7)) << PAGE_SHIFT | $urandom_range(0, 4095);
    return $urandom();
  endfunction

  task automatic send_random_request();
    int r;
    r = $urandom_range(99);
    if (r < 45) send_request(OP_ALLOC, $urandom());
    else if (r < 70) send_request(OP_FREE, pick_address());
    else if (r < 95) send_request(OP_QUERY, pick_address());
    else send_request(OP_NONE, $urandom());
  endtask

  task automatic test_basic_ops();
    send_request(OP_QUERY, 32'h0000_0000);
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_QUERY, 32'h0000_0FFF);
    send_request(OP_FREE, 32'h0000_0ABC);
    send_request(OP_FREE, 32'h0000_0000);
    send_request(OP_QUERY, 32'h0000_0000);
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_QUERY, 32'h7FFF_FFFF);
    send_request(OP_FREE, 32'h0800_0000);
    send_request(OP_QUERY, 32'hFFFF_FFFF);
    send_request(OP_NONE, 32'hFFFF_FFFF);
    send_request(OP_ALLOC, 32'hFFFF_FFFF);
    wait_results_done();
  endtask

  task automatic test_config_extremes();
    write_bytes_in_use('0);
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_FREE, 32'h0000_0000);
    send_request(OP_QUERY, 32'h0000_0000);
    wait_results_done();
    write_bytes_in_use(13'h1FFF);
    send_request(OP_QUERY, 32'h7FFF_F000);
    send_request(OP_QUERY, 32'h0800_0000);
    wait_results_done();
    write_bytes_in_use(13'd1);
    repeat (6) send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_QUERY, 32'h0000_8000);
    wait_results_done();
    write_bytes_in_use(CFG_RESET);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    int sent;
    int seg;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < count) begin
      wait_results_done();
      write_bytes_in_use(pick_bytes_in_use());
      seg = $urandom_range(20, 60);
      for (int i = 0; i < seg && sent < count; i++) begin
        send_random_request();
        sent++;
      end
    end
    wait_results_done();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_results_done();
    write_bytes_in_use(13'd64);
    @(posedge clk);
    hold_cycles = 300;
    repeat (16) send_random_request();
    // sender pauses until the block has answered everything
    wait_results_done();
    repeat (10) send_random_request();
    wait_results_done();
  endtask

  initial begin
    foreach (page_map[i]) page_map[i] = 8'h00;
    bytes_in_use_q = CFG_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_config_extremes();
    test_random_traffic(15, 73, 300);
    test_random_traffic(73, 15, 300);
    test_random_traffic(0, 0, 300);
    test_backpressure();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
